// File: rtl/bds_pkg.sv
// Block average downscaler: shared constants, codes and types.
// No dependencies; compiled first.
package bds_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_TILE_DEF  = 64;
    localparam int MAX_HEIGHT    = 2048;

    localparam int PIX_W      = 8;
    localparam int TILE_REG_W = 7;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_SIZE    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } bds_flags_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } bk_state_t;

endpackage

// File: rtl/bds_if.sv
// Channel interfaces: pixel input, tile result output, register write.
// Depends on bds_pkg.
interface bds_pix_if;
    import bds_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    modport source (output valid, blue, green, red, input ready);
    modport sink   (input valid, blue, green, red, output ready);
endinterface

interface bds_res_if;
    import bds_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mean_red;
    logic [PIX_W-1:0] mean_green;
    logic [PIX_W-1:0] mean_blue;
    logic             row_end;
    logic             frame_end;
    modport source (output valid, mean_red, mean_green, mean_blue, row_end, frame_end,
                    input ready);
    modport sink   (input valid, mean_red, mean_green, mean_blue, row_end, frame_end,
                    output ready);
endinterface

interface bds_cfg_if;
    import bds_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bds_front.sv
// Front end: pixel acceptance, tile position counters and per-column sum memory.
// Pushes finished tile sums into the queue. Depends on bds_pkg, bds_if.
module bds_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_TILE  = 64,
    parameter int SUM_W     = 8 + 2 * $clog2(MAX_TILE),
    parameter int CNT_W     = 2 * $clog2(MAX_TILE) + 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bds_pix_if.sink                           pix,
    input  logic [bds_pkg::TILE_REG_W-1:0]    tile_size,
    input  logic [bds_pkg::DIM_W-1:0]         frame_width,
    input  logic [bds_pkg::DIM_W-1:0]         frame_height,
    input  logic                              q_full,
    output logic                              q_push,
    output logic [3*SUM_W-1:0]                q_sums,
    output logic [CNT_W-1:0]                  q_count,
    output bds_pkg::bds_flags_t               q_flags
);
    import bds_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int TW  = $clog2(MAX_TILE);
    localparam int TSW = $clog2(MAX_TILE + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] pc_reg, pc_next;
    logic [RW-1:0] pr_reg, pr_next;
    logic [TW-1:0] cit_reg, cit_next;
    logic [TW-1:0] rit_reg, rit_next;
    logic [CW-1:0] tc_reg, tc_next;
    logic          busy_reg;

    logic [TSW-1:0] ts_c;
    logic [EW-1:0]  w_c;
    logic [HW-1:0]  h_c;
    logic           accept, last_col, last_row, col_end, row_end_t, tile_end;

    // second stage: read-modify-write of the column sums
    logic [PIX_W-1:0]   r_s_reg, g_s_reg, b_s_reg;
    logic               first_s_reg, tile_end_s_reg;
    logic [CW-1:0]      idx_s_reg;
    logic [CNT_W-1:0]   count_s_reg;
    bds_flags_t         flags_s_reg;
    logic [3*SUM_W-1:0] rd_reg;
    logic [3*SUM_W-1:0] new_sums;
    logic [3*SUM_W-1:0] sum_mem [MAX_WIDTH];

    always_comb
    begin
        if (tile_size == '0)
            ts_c = TSW'(1);
        else if (32'(tile_size) > MAX_TILE)
            ts_c = TSW'(MAX_TILE);
        else
            ts_c = TSW'(tile_size);
        if (frame_width == '0)
            w_c = EW'(1);
        else if (32'(frame_width) > MAX_WIDTH)
            w_c = EW'(MAX_WIDTH);
        else
            w_c = EW'(frame_width);
        if (frame_height == '0)
            h_c = HW'(1);
        else if (32'(frame_height) > MAX_HEIGHT)
            h_c = HW'(MAX_HEIGHT);
        else
            h_c = HW'(frame_height);
    end

    assign pix.ready = !busy_reg && !q_full;
    assign accept    = pix.valid && pix.ready;

    assign last_col  = (EW'(pc_reg) + EW'(1)) >= w_c;
    assign last_row  = (HW'(pr_reg) + HW'(1)) >= h_c;
    assign col_end   = last_col || ((TSW'(cit_reg) + TSW'(1)) >= ts_c);
    assign row_end_t = last_row || ((TSW'(rit_reg) + TSW'(1)) >= ts_c);
    assign tile_end  = col_end && row_end_t;

    always_comb
    begin
        pc_next  = pc_reg;
        pr_next  = pr_reg;
        cit_next = cit_reg;
        rit_next = rit_reg;
        tc_next  = tc_reg;
        if (accept)
        begin
            if (last_col)
            begin
                pc_next  = '0;
                cit_next = '0;
                tc_next  = '0;
                if (last_row)
                begin
                    pr_next  = '0;
                    rit_next = '0;
                end
                else
                begin
                    pr_next  = pr_reg + RW'(1);
                    rit_next = row_end_t ? '0 : rit_reg + TW'(1);
                end
            end
            else
            begin
                pc_next = pc_reg + CW'(1);
                if (col_end)
                begin
                    cit_next = '0;
                    tc_next  = (tc_reg == CW'(MAX_WIDTH - 1)) ? '0 : tc_reg + CW'(1);
                end
                else
                    cit_next = cit_reg + TW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            pr_reg   <= '0;
            cit_reg  <= '0;
            rit_reg  <= '0;
            tc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            pr_reg   <= pr_next;
            cit_reg  <= cit_next;
            rit_reg  <= rit_next;
            tc_reg   <= tc_next;
            busy_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_s_reg        <= pix.red;
            g_s_reg        <= pix.green;
            b_s_reg        <= pix.blue;
            first_s_reg    <= (cit_reg == '0) && (rit_reg == '0);
            tile_end_s_reg <= tile_end;
            idx_s_reg      <= tc_reg;
            count_s_reg    <= CNT_W'((CNT_W'(cit_reg) + CNT_W'(1)) *
                                     (CNT_W'(rit_reg) + CNT_W'(1)));
            flags_s_reg.row_end   <= last_col;
            flags_s_reg.frame_end <= last_col && last_row;
        end
    end

    // memory: read at accept, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= sum_mem[tc_reg];
        if (busy_reg)
            sum_mem[idx_s_reg] <= new_sums;
    end

    always_comb
    begin
        if (first_s_reg)
            new_sums = {SUM_W'(r_s_reg), SUM_W'(g_s_reg), SUM_W'(b_s_reg)};
        else
            new_sums = {rd_reg[3*SUM_W-1:2*SUM_W] + SUM_W'(r_s_reg),
                        rd_reg[2*SUM_W-1:SUM_W]   + SUM_W'(g_s_reg),
                        rd_reg[SUM_W-1:0]         + SUM_W'(b_s_reg)};
    end

    assign q_push  = busy_reg && tile_end_s_reg;
    assign q_sums  = new_sums;
    assign q_count = count_s_reg;
    assign q_flags = flags_s_reg;

endmodule

// File: rtl/bds_fifo.sv
// Two-entry request queue between front and back end.
// Depends on nothing else.
module bds_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);
    logic [W-1:0] data_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign dout  = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= din;
    end

endmodule

// File: rtl/bds_back.sv
// Back end: restoring divider (one quotient bit per cycle, three channels at
// once) and the result output register. Depends on bds_pkg, bds_if.
module bds_back #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  logic [3*SUM_W-1:0]  q_sums,
    input  logic [CNT_W-1:0]    q_count,
    input  bds_pkg::bds_flags_t q_flags,
    output logic                q_pop,
    bds_res_if.source           res
);
    import bds_pkg::*;

    localparam int SW = $clog2(SUM_W + 1);

    bk_state_t state_reg, state_next;

    logic [SUM_W-1:0] dvd_reg [3];
    logic [CNT_W-1:0] rem_reg [3];
    logic [CNT_W-1:0] div_reg;
    logic [SW-1:0]    step_reg;
    bds_flags_t       flags_reg;
    logic             load_out;

    logic [PIX_W-1:0] mean_reg [3];
    logic             out_valid_reg;
    bds_flags_t       out_flags_reg;

    logic [CNT_W:0]   rem_sh [3];
    logic             qbit [3];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_RUN;
            BK_RUN:  if (step_reg == SW'(1)) state_next = BK_DONE;
            BK_DONE: if (!out_valid_reg || res.ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == BK_IDLE) && !q_empty;
        load_out = (state_reg == BK_DONE) && (!out_valid_reg || res.ready);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_sh[i] = {rem_reg[i], dvd_reg[i][SUM_W-1]};
            qbit[i]   = rem_sh[i] >= {1'b0, div_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dvd_reg[0] <= q_sums[3*SUM_W-1:2*SUM_W];
            dvd_reg[1] <= q_sums[2*SUM_W-1:SUM_W];
            dvd_reg[2] <= q_sums[SUM_W-1:0];
            for (int i = 0; i < 3; i++)
                rem_reg[i] <= '0;
            div_reg   <= q_count;
            step_reg  <= SW'(SUM_W);
            flags_reg <= q_flags;
        end
        else if (state_reg == BK_RUN)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dvd_reg[i] <= {dvd_reg[i][SUM_W-2:0], qbit[i]};
                rem_reg[i] <= qbit[i] ? CNT_W'(rem_sh[i] - {1'b0, div_reg})
                                      : CNT_W'(rem_sh[i]);
            end
            step_reg <= step_reg - SW'(1);
        end
        if (load_out)
        begin
            for (int i = 0; i < 3; i++)
                mean_reg[i] <= (|dvd_reg[i][SUM_W-1:PIX_W]) ? '1 : dvd_reg[i][PIX_W-1:0];
            out_flags_reg <= flags_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.mean_red   = mean_reg[0];
    assign res.mean_green = mean_reg[1];
    assign res.mean_blue  = mean_reg[2];
    assign res.row_end    = out_flags_reg.row_end;
    assign res.frame_end  = out_flags_reg.frame_end;

endmodule

// File: rtl/block_average_downscaler_unit.sv
// Block average downscaler. In the front end each pixel's column sum is read
// from the sum memory and then written back; no pixel is accepted during the
// write back or while the queue is full. The back-end divider works one
// quotient bit per cycle and pops the next tile only once it is idle again.
// Reset clears counters, queue and valid flags; registers return to
// tile 1, 640 x 480. The sum memory is not cleared.
module block_average_downscaler_unit #(
    parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF,
    parameter int MAX_TILE  = bds_pkg::MAX_TILE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bds_pix_if.sink    pix,
    bds_res_if.source  res,
    bds_cfg_if.sink    cfg
);
    import bds_pkg::*;

    localparam int SUM_W = PIX_W + 2 * $clog2(MAX_TILE);
    localparam int CNT_W = 2 * $clog2(MAX_TILE) + 1;
    localparam int QW    = 3 * SUM_W + CNT_W + $bits(bds_flags_t);

    logic [TILE_REG_W-1:0] tile_size_reg;
    logic [DIM_W-1:0]      frame_width_reg;
    logic [DIM_W-1:0]      frame_height_reg;

    logic               q_push, q_pop, q_full, q_empty;
    logic [3*SUM_W-1:0] f_sums, b_sums;
    logic [CNT_W-1:0]   f_count, b_count;
    bds_flags_t         f_flags, b_flags;
    logic [QW-1:0]      q_dout;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_size_reg    <= TILE_REG_W'(1);
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TILE_SIZE:    tile_size_reg    <= cfg.data[TILE_REG_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    bds_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TILE  (MAX_TILE),
        .SUM_W     (SUM_W),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix          (pix),
        .tile_size    (tile_size_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_sums       (f_sums),
        .q_count      (f_count),
        .q_flags      (f_flags)
    );

    bds_fifo #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_sums, f_count, f_flags}),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    assign b_sums  = q_dout[QW-1 -: 3*SUM_W];
    assign b_count = q_dout[CNT_W+$bits(bds_flags_t)-1 -: CNT_W];
    assign b_flags = q_dout[$bits(bds_flags_t)-1:0];

    bds_back #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_sums  (b_sums),
        .q_count (b_count),
        .q_flags (b_flags),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

// File: rtl/bds_checker.sv
// Port-level checks for the block average downscaler, bound to the top level.
// Depends on block_average_downscaler_unit.
module bds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_mean_red,
    input logic       res_row_end,
    input logic       res_frame_end
);
    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_mean_red))
        else $error("result changed while stalled");

    // last tile of the frame is always last of its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res_frame_end || res_row_end))
        else $error("frame end without row end");

    // sum memory read-modify-write blocks pixel acceptance in the cycle after an accept
    a_pix_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready)
        else $error("pixel accepted during write back");
endmodule

bind block_average_downscaler_unit bds_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_valid     (pix.valid),
    .pix_ready     (pix.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_mean_red  (res.mean_red),
    .res_row_end   (res.row_end),
    .res_frame_end (res.frame_end)
);
